/* rtl/vvst_pkg.sv */
// shared types and constants for the vertical speed tracker
`default_nettype none
package vvst_pkg;
	localparam int ALT_W       = 21;
	localparam int REL_W       = 22;
	localparam int DIFF_W      = 23;
	localparam int SPD_W       = 15;
	localparam int TIME_W      = 32;
	localparam int LIM_W       = 14;
	localparam int AGE_W       = 16;
	localparam int QUO_W       = 32;
	localparam int SCALE_MS    = 1000;
	localparam int DIV_STEPS   = QUO_W;
	localparam int DEF_RING_DEPTH = 16;

	localparam int S_TDATA_W   = 56;
	localparam int M_TDATA_W   = 40;
	localparam int M_PAD_W     = M_TDATA_W - REL_W - SPD_W;
	localparam int S_PAD_W     = S_TDATA_W - ALT_W - TIME_W;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 4;

	localparam logic [1:0] REG_SENSOR_EN = 2'd0;
	localparam logic [1:0] REG_MAX_SPEED = 2'd1;
	localparam logic [1:0] REG_MAX_AGE   = 2'd2;

	localparam logic [LIM_W-1:0] MAX_SPEED_RST = LIM_W'(2000);
	localparam logic [AGE_W-1:0] MAX_AGE_RST   = AGE_W'(1000);

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_GROUND = 1'b1;

	typedef struct packed {
		logic             sensor_enabled;
		logic [LIM_W-1:0] speed_limit;
		logic [AGE_W-1:0] max_age_ms;
	} cfg_t;

	typedef struct packed {
		logic signed [REL_W-1:0] alt;
		logic [TIME_W-1:0]       stamp;
	} ring_entry_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic diff;
		logic scale;
		logic div_step;
		logic clamp;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic need_speed;
		logic dt_zero;
	} dp_status_t;
endpackage
`default_nettype wire

/* rtl/vvst_regs.sv */
// configuration registers behind the apb port
`default_nettype none
module vvst_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [vvst_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [vvst_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [vvst_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	output vvst_pkg::cfg_t                       cfg
);
	import vvst_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_enabled <= 1'b0;
			cfg_q.speed_limit    <= MAX_SPEED_RST;
			cfg_q.max_age_ms     <= MAX_AGE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SENSOR_EN: cfg_q.sensor_enabled <= pwdata[0];
				REG_MAX_SPEED: cfg_q.speed_limit    <= pwdata[LIM_W-1:0];
				REG_MAX_AGE:   cfg_q.max_age_ms     <= pwdata[AGE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SENSOR_EN: prdata = APB_DATA_W'(cfg_q.sensor_enabled);
			REG_MAX_SPEED: prdata = APB_DATA_W'(cfg_q.speed_limit);
			REG_MAX_AGE:   prdata = APB_DATA_W'(cfg_q.max_age_ms);
			default:       prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/vvst_ctrl.sv */
// sequencing state machine for one request at a time
`default_nettype none
module vvst_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	input  wire vvst_pkg::dp_status_t status,
	output vvst_pkg::dp_cmd_t         cmd
);
	import vvst_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_READ,
		ST_DIFF,
		ST_SCALE,
		ST_DIV,
		ST_CLAMP,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              m_tvalid_q;
	logic              out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd          = '0;
		cmd.capture  = s_tvalid && (state_q == ST_IDLE);
		cmd.eval     = (state_q == ST_EVAL);
		cmd.diff     = (state_q == ST_DIFF);
		cmd.scale    = (state_q == ST_SCALE);
		cmd.div_step = (state_q == ST_DIV);
		cmd.clamp    = (state_q == ST_CLAMP);
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= status.need_speed ? ST_READ : ST_DONE;
				end
				ST_READ: begin
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					cnt_q   <= '0;
					state_q <= status.dt_zero ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transaction taken while one is in progress");
	a_div_count_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCALE && !status.dt_zero |=> cnt_q == '0)
		else $error("divider count not cleared at start");
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_tvalid)
		else $error("loaded result not presented");
`endif
endmodule
`default_nettype wire

/* rtl/vvst_dp.sv */
// datapath: ring memory, held snapshot, serial divider and clamp
`default_nettype none
module vvst_dp #(
	parameter int RING_DEPTH = vvst_pkg::DEF_RING_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire vvst_pkg::cfg_t                 cfg,
	input  wire logic [vvst_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic [0:0]                     s_tuser,
	output logic      [vvst_pkg::M_TDATA_W-1:0] m_tdata,
	output logic      [1:0]                     m_tuser,
	input  wire vvst_pkg::dp_cmd_t              cmd,
	output vvst_pkg::dp_status_t                status
);
	import vvst_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam logic [CW:0] DEPTH_X = (CW + 1)'(RING_DEPTH);

	ring_entry_t ring_mem [RING_DEPTH];
	ring_entry_t rd_q;

	// captured request
	logic                     req_q;
	logic signed [ALT_W-1:0]  abs_q;
	logic [TIME_W-1:0]        t_q;

	// held state
	logic [AW-1:0]            head_q;
	logic [CW-1:0]            count_q;
	logic [AW-1:0]            oldest_q;
	logic signed [ALT_W-1:0]  ground_q;
	logic signed [ALT_W-1:0]  last_abs_q;
	logic signed [REL_W-1:0]  last_rel_q;
	logic signed [SPD_W-1:0]  last_speed_q;
	logic [TIME_W-1:0]        last_time_q;
	logic                     last_valid_q;
	logic                     ok_q;

	// speed path
	logic signed [DIFF_W-1:0] diff_q;
	logic [TIME_W-1:0]        dt_q;
	logic                     neg_q;
	logic [QUO_W:0]           rem_q;
	logic [QUO_W-1:0]         quo_q;
	logic [TIME_W-1:0]        dvs_q;

	logic [M_TDATA_W-1:0]     out_data_q;
	logic [1:0]               out_user_q;

	logic signed [REL_W-1:0]  rel;
	logic [TIME_W-1:0]        age;
	logic                     age_ok;
	logic                     do_sample;
	logic                     do_ground;
	logic [AW-1:0]            head_nx;
	logic [CW-1:0]            count_nx;
	logic [CW:0]              oldest_sum;
	logic [CW:0]              oldest_wrap;
	logic [DIFF_W-1:0]        diff_abs;
	logic [QUO_W-1:0]         scaled;
	logic [QUO_W:0]           rem_sh;
	logic                     fits;
	logic [LIM_W-1:0]         clamp_mag;
	logic [SPD_W-1:0]         mag_ext;

	assign rel       = REL_W'(abs_q) - REL_W'(ground_q);
	assign age       = t_q - last_time_q;
	assign age_ok    = age <= TIME_W'(cfg.max_age_ms);
	assign do_sample = cfg.sensor_enabled && (req_q == REQ_SAMPLE);
	assign do_ground = cfg.sensor_enabled && (req_q == REQ_GROUND) && last_valid_q && age_ok;

	assign head_nx  = (head_q == AW'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign count_nx = (count_q == CW'(RING_DEPTH)) ? count_q : count_q + 1'b1;

	// oldest entry sits count places behind the next write slot
	assign oldest_sum  = (CW + 1)'(head_nx) + DEPTH_X - (CW + 1)'(count_nx);
	assign oldest_wrap = (oldest_sum >= DEPTH_X) ? oldest_sum - DEPTH_X : oldest_sum;

	assign status.need_speed = do_sample && (count_nx >= CW'(2));
	assign status.dt_zero    = (dt_q == '0);

	assign diff_abs = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
	assign scaled   = QUO_W'(diff_abs[REL_W-1:0]) * QUO_W'(SCALE_MS);

	assign rem_sh = {rem_q[QUO_W-1:0], quo_q[QUO_W-1]};
	assign fits   = rem_sh >= (QUO_W + 1)'(dvs_q);

	assign clamp_mag = (quo_q > QUO_W'(cfg.speed_limit)) ?
		cfg.speed_limit : quo_q[LIM_W-1:0];
	assign mag_ext   = SPD_W'(clamp_mag);

	always_ff @(posedge clk) begin
		if (cmd.eval && do_sample) begin
			ring_mem[head_q] <= '{alt: rel, stamp: t_q};
		end
		rd_q <= ring_mem[oldest_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= s_tuser[0];
			abs_q <= s_tdata[ALT_W-1:0];
			t_q   <= s_tdata[ALT_W+TIME_W-1:ALT_W];
		end
		if (cmd.eval) begin
			oldest_q <= oldest_wrap[AW-1:0];
		end
		if (cmd.diff) begin
			diff_q <= DIFF_W'(last_rel_q) - DIFF_W'(rd_q.alt);
			dt_q   <= t_q - rd_q.stamp;
		end
		if (cmd.scale) begin
			neg_q <= diff_q[DIFF_W-1];
			rem_q <= '0;
			quo_q <= scaled;
			dvs_q <= dt_q;
		end else if (cmd.div_step) begin
			rem_q <= fits ? rem_sh - (QUO_W + 1)'(dvs_q) : rem_sh;
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
		if (cmd.load_out) begin
			out_data_q <= {M_PAD_W'(0), last_speed_q, last_rel_q};
			out_user_q <= {last_valid_q, ok_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			count_q      <= '0;
			ground_q     <= '0;
			last_abs_q   <= '0;
			last_rel_q   <= '0;
			last_speed_q <= '0;
			last_time_q  <= '0;
			last_valid_q <= 1'b0;
			ok_q         <= 1'b0;
		end else begin
			if (cmd.eval) begin
				ok_q <= do_sample || do_ground;
				if (do_sample) begin
					head_q       <= head_nx;
					count_q      <= count_nx;
					last_abs_q   <= abs_q;
					last_rel_q   <= rel;
					last_time_q  <= t_q;
					last_valid_q <= 1'b1;
					if (count_nx < CW'(2)) begin
						last_speed_q <= '0;
					end
				end else if (do_ground) begin
					ground_q     <= last_abs_q;
					last_rel_q   <= '0;
					last_speed_q <= '0;
					head_q       <= '0;
					count_q      <= '0;
				end
			end
			if (cmd.scale && status.dt_zero) begin
				last_speed_q <= '0;
			end
			if (cmd.clamp) begin
				last_speed_q <= neg_q ? SPD_W'(-mag_ext) : mag_ext;
			end
		end
	end

	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(RING_DEPTH))
		else $error("ring fill count beyond depth");
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= AW'(RING_DEPTH - 1))
		else $error("ring head beyond depth");
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> dvs_q != '0)
		else $error("divide step with zero divisor");
`endif
endmodule
`default_nettype wire

/* rtl/vario_vertical_speed_tracker.sv */
// Vertical speed tracker. Each request on the input stream gives one result on the output
// stream, one request in progress at a time. A sample stores ground-relative altitude in a
// ring of the last RING_DEPTH samples; once two or more are held the speed is worked out by
// a one-bit-per-cycle divider whose 32 steps set the pace; the next request can be taken in
// the cycle that presents the result. With a zero time gap the divider is skipped. A
// disabled request, a set-ground request and the first sample after reset or set ground
// go straight to the result stage. The result waits in an output register, and the next
// request is taken while it waits; that request holds at its result stage until the
// waiting one is taken. The ring needs no clearing after reset.
`default_nettype none
module vario_vertical_speed_tracker #(
	parameter int RING_DEPTH = vvst_pkg::DEF_RING_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [vvst_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [vvst_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [vvst_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// abs_altitude_cm [20:0], time_ms [52:21], zero pad
	input  wire logic [vvst_pkg::S_TDATA_W-1:0]  s_tdata,
	// req_type [0]
	input  wire logic [0:0]                      s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// rel_altitude_cm [21:0], vertical_speed_cms [36:22], zero pad
	output logic      [vvst_pkg::M_TDATA_W-1:0]  m_tdata,
	// ok [0], snapshot_valid [1]
	output logic      [1:0]                      m_tuser
);
	import vvst_pkg::*;

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	vvst_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vvst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	vvst_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.cmd     (cmd),
		.status  (status)
	);
endmodule
`default_nettype wire

/* tb/sv/vvst_tracker_monitor.sv */
// scoreboard for the vertical speed tracker: predicts every result and checks the output stream
module vvst_tracker_monitor
	import vvst_pkg::*;
#(
	parameter int RING_DEPTH = DEF_RING_DEPTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic                   pready,
	input  wire logic [APB_ADDR_W-1:0]  paddr,
	input  wire logic [APB_DATA_W-1:0]  pwdata,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	// abs_altitude_cm [20:0], time_ms [52:21], zero pad
	input  wire logic [S_TDATA_W-1:0]   s_tdata,
	// req_type [0]
	input  wire logic [0:0]             s_tuser,
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	// rel_altitude_cm [21:0], vertical_speed_cms [36:22], zero pad
	input  wire logic [M_TDATA_W-1:0]   m_tdata,
	// ok [0], snapshot_valid [1]
	input  wire logic [1:0]             m_tuser,
	output int                          mismatches,
	output int                          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_CAP = 64;

	typedef struct packed {
		logic                    ok;
		logic signed [REL_W-1:0] rel_cm;
		logic signed [SPD_W-1:0] speed;
		logic                    snap_valid;
	} reading_t;

	reading_t                expected_readings[$];
	logic signed [REL_W-1:0] ring_rel_cm[RING_DEPTH];
	logic [TIME_W-1:0]       ring_stamp_ms[RING_DEPTH];
	int                      ring_wr_ptr;
	int                      ring_fill;
	logic signed [ALT_W-1:0] ground_cm;
	logic signed [ALT_W-1:0] held_abs_cm;
	logic signed [REL_W-1:0] held_rel_cm;
	logic signed [SPD_W-1:0] held_speed;
	logic [TIME_W-1:0]       held_stamp;
	logic                    held_valid;
	logic                    cfg_enabled;
	logic [LIM_W-1:0]        cfg_speed_limit;
	logic [AGE_W-1:0]        cfg_age_limit;

	// climb rate between the newest and oldest ring entries, clamped
	function automatic logic signed [SPD_W-1:0] ring_climb_rate();
		int                newest;
		int                oldest;
		logic [TIME_W-1:0] gap_ms;
		longint            rise;
		longint            rate;
		longint            lim;
		if (ring_fill < 2)
			return '0;
		newest = (ring_wr_ptr + RING_DEPTH - 1) % RING_DEPTH;
		oldest = (ring_wr_ptr + RING_DEPTH - ring_fill) % RING_DEPTH;
		// timestamps out of order still give an unsigned wrapped gap
		gap_ms = ring_stamp_ms[newest] - ring_stamp_ms[oldest];
		if (gap_ms == '0)
			return '0;
		rise = (longint'(ring_rel_cm[newest]) - longint'(ring_rel_cm[oldest])) * SCALE_MS;
		rate = rise / longint'({32'b0, gap_ms});
		lim  = longint'(cfg_speed_limit);
		if (rate > lim)
			rate = lim;
		if (rate < -lim)
			rate = -lim;
		return SPD_W'(rate);
	endfunction

	function automatic reading_t predict_reading(logic req, logic signed [ALT_W-1:0] abs_cm,
			logic [TIME_W-1:0] stamp);
		reading_t          r;
		logic [TIME_W-1:0] age_ms;
		r.ok   = 1'b0;
		age_ms = stamp - held_stamp;
		if (cfg_enabled && req == REQ_SAMPLE) begin
			held_rel_cm = REL_W'(longint'(abs_cm) - longint'(ground_cm));
			ring_rel_cm[ring_wr_ptr]   = held_rel_cm;
			ring_stamp_ms[ring_wr_ptr] = stamp;
			ring_wr_ptr = (ring_wr_ptr + 1) % RING_DEPTH;
			if (ring_fill < RING_DEPTH)
				ring_fill++;
			held_abs_cm = abs_cm;
			held_speed  = ring_climb_rate();
			held_stamp  = stamp;
			held_valid  = 1'b1;
			r.ok        = 1'b1;
		end else if (cfg_enabled && held_valid && age_ms <= cfg_age_limit) begin
			// set ground: keeps the valid flag and sample time, empties the ring
			ground_cm   = held_abs_cm;
			held_rel_cm = '0;
			held_speed  = '0;
			ring_wr_ptr = 0;
			ring_fill   = 0;
			r.ok        = 1'b1;
		end
		r.rel_cm     = held_rel_cm;
		r.speed      = held_speed;
		r.snap_valid = held_valid;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		reading_t got;
		logic     bad;
		if (!arst_n) begin
			expected_readings.delete();
			foreach (ring_rel_cm[i]) begin
				ring_rel_cm[i]   = '0;
				ring_stamp_ms[i] = '0;
			end
			ring_wr_ptr     = 0;
			ring_fill       = 0;
			ground_cm       = '0;
			held_abs_cm     = '0;
			held_rel_cm     = '0;
			held_speed      = '0;
			held_stamp      = '0;
			held_valid      = 1'b0;
			cfg_enabled     = 1'b0;
			cfg_speed_limit = MAX_SPEED_RST;
			cfg_age_limit   = MAX_AGE_RST;
			mismatches      = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.ok         = m_tuser[0];
				got.snap_valid = m_tuser[1];
				got.rel_cm     = m_tdata[REL_W-1:0];
				got.speed      = m_tdata[REL_W+SPD_W-1:REL_W];
				if (expected_readings.size() == 0) begin
					if (mismatches < REPORT_CAP)
						$display("%0t: result transaction with nothing expected, actual %p",
							$time, got);
					mismatches++;
				end else begin
					want = expected_readings.pop_front();
					bad  = 1'b0;
					if (got.ok !== want.ok) begin
						bad = 1'b1;
						if (mismatches < REPORT_CAP)
							$display("%0t: ok expected %0d actual %0d",
								$time, want.ok, got.ok);
					end
					if (got.rel_cm !== want.rel_cm) begin
						bad = 1'b1;
						if (mismatches < REPORT_CAP)
							$display("%0t: rel_altitude_cm expected %0d actual %0d",
								$time, want.rel_cm, got.rel_cm);
					end
					if (got.speed !== want.speed) begin
						bad = 1'b1;
						if (mismatches < REPORT_CAP)
							$display("%0t: vertical_speed_cms expected %0d actual %0d",
								$time, want.speed, got.speed);
					end
					if (got.snap_valid !== want.snap_valid) begin
						bad = 1'b1;
						if (mismatches < REPORT_CAP)
							$display("%0t: snapshot_valid expected %0d actual %0d",
								$time, want.snap_valid, got.snap_valid);
					end
					if (bad)
						mismatches++;
				end
			end
			if (s_tvalid && s_tready)
				expected_readings.push_back(predict_reading(s_tuser[0], s_tdata[ALT_W-1:0],
					s_tdata[ALT_W+TIME_W-1:ALT_W]));
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_W-1:2])
					REG_SENSOR_EN: cfg_enabled     = pwdata[0];
					REG_MAX_SPEED: cfg_speed_limit = pwdata[LIM_W-1:0];
					REG_MAX_AGE:   cfg_age_limit   = pwdata[AGE_W-1:0];
					default: ;
				endcase
			end
		end
		outstanding = expected_readings.size();
	end
endmodule

/* tb/sv/vario_vertical_speed_tracker_tb.sv */
// top of the vertical speed tracker testbench: clock, reset, stimulus and verdict
module vario_vertical_speed_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vvst_pkg::*;

	localparam int ITEM_TARGET  = 1950;
	localparam int IDLE_LIMIT   = 5000;
	localparam int LONG_STALL   = 400;
	localparam int DRAIN_CYCLES = 60;

	localparam logic [1:0]       REG_UNMAPPED = 2'd3;
	localparam logic [ALT_W-1:0] ALT_MIN = {1'b1, {(ALT_W-1){1'b0}}};
	localparam logic [ALT_W-1:0] ALT_MAX = {1'b0, {(ALT_W-1){1'b1}}};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [0:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [1:0]            m_tuser;

	int mismatches;
	int outstanding;
	int snd_idle = 36;
	int rcv_idle = 46;
	int items_sent = 0;
	bit long_stall_pending = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	vario_vertical_speed_tracker DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	vvst_tracker_monitor u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// receiver: random back-pressure, plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_stall_pending) begin
				m_tready <= 1'b0;
				repeat (LONG_STALL) @(negedge clk);
				long_stall_pending = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	// watchdog on cycles with no transaction on either stream
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("vario_vertical_speed_tracker regression: fail");
		$finish;
	end

	// called at a falling edge, returns at a falling edge after the access
	task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic offer_request(input logic req, input logic [ALT_W-1:0] abs_cm,
			input logic [TIME_W-1:0] stamp);
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {{S_PAD_W{1'b0}}, stamp, abs_cm};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		int                ep;
		int                pick;
		int                seq_alt;
		logic [TIME_W-1:0] seq_time;
		logic [TIME_W-1:0] noise_t;
		logic [ALT_W-1:0]  noise_abs;
		logic              noise_req;
		logic              enable;
		logic [LIM_W-1:0]  speed_lim;
		logic [AGE_W-1:0]  age_lim;

		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sensor still disabled after reset
		offer_request(REQ_SAMPLE, 21'd12345, 32'd100);
		offer_request(REQ_GROUND, '0, 32'd100);
		drain_results();
		// upper bits are masked off by the block
		write_reg(REG_SENSOR_EN, 32'hFFFF_FFFF);
		write_reg(REG_MAX_SPEED, 32'hFFFF_FFFF);
		write_reg(REG_MAX_AGE, 32'hFFFF_FFFF);
		write_reg(REG_UNMAPPED, 32'h0);

		offer_request(REQ_GROUND, '1, 32'd5);
		offer_request(REQ_SAMPLE, ALT_MIN, 32'd0);
		offer_request(REQ_SAMPLE, ALT_MAX, 32'd0);
		offer_request(REQ_SAMPLE, '0, 32'd1);
		offer_request(REQ_SAMPLE, ALT_MAX, 32'hFFFF_FFFF);
		offer_request(REQ_GROUND, '0, 32'h0000_FFFE);
		offer_request(REQ_GROUND, '0, 32'h0000_FFFF);
		offer_request(REQ_SAMPLE, ALT_MIN, 32'h10);
		offer_request(REQ_SAMPLE, ALT_MAX, 32'h0F);
		offer_request(REQ_SAMPLE, ALT_MIN, 32'h11);
		offer_request(REQ_SAMPLE, ALT_MAX, 32'h12);
		offer_request(REQ_GROUND, '0, 32'h12);
		offer_request(REQ_SAMPLE, ALT_MAX, 32'h20);
		offer_request(REQ_SAMPLE, ALT_MIN, 32'h21);
		drain_results();
		write_reg(REG_MAX_SPEED, 32'h0);
		write_reg(REG_MAX_AGE, 32'h0);
		offer_request(REQ_SAMPLE, '0, 32'h22);
		offer_request(REQ_GROUND, '0, 32'h23);
		offer_request(REQ_GROUND, '0, 32'h22);
		drain_results();
		write_reg(REG_SENSOR_EN, 32'h0);
		offer_request(REQ_SAMPLE, ALT_MAX, 32'h30);
		offer_request(REQ_GROUND, '0, 32'h30);
		drain_results();

		// random flights, new register settings between them
		ep       = 0;
		seq_time = '0;
		seq_alt  = 0;
		while (items_sent < ITEM_TARGET) begin
			if (items_sent < ITEM_TARGET / 3) begin
				snd_idle = 36;
				rcv_idle = 46;
			end else if (items_sent < 2 * ITEM_TARGET / 3) begin
				snd_idle = 46;
				rcv_idle = 36;
			end else begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			enable = ($urandom_range(9) != 0);
			case ($urandom_range(4))
				0:       speed_lim = '0;
				1:       speed_lim = '1;
				2:       speed_lim = LIM_W'(10000);
				default: speed_lim = LIM_W'($urandom_range(1, 10000));
			endcase
			case ($urandom_range(3))
				0:       age_lim = '0;
				1:       age_lim = '1;
				default: age_lim = AGE_W'($urandom_range(0, 3000));
			endcase
			write_reg(REG_SENSOR_EN, {{(APB_DATA_W-1){1'b0}}, enable});
			write_reg(REG_MAX_SPEED, APB_DATA_W'(speed_lim));
			write_reg(REG_MAX_AGE, APB_DATA_W'(age_lim));
			if ($urandom_range(3) == 0)
				seq_time = $urandom_range(1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 800);
			// receiver holds off while the sender keeps offering
			if (ep % 16 == 3)
				long_stall_pending = 1'b1;
			repeat ($urandom_range(30, 70)) begin
				pick = $urandom_range(99);
				if (pick < 76) begin
					seq_time += $urandom_range(0, 60);
					seq_alt  += int'($urandom_range(0, 1200)) - 600;
					if (seq_alt > int'($signed(ALT_MAX)))
						seq_alt = int'($signed(ALT_MAX));
					if (seq_alt < int'($signed(ALT_MIN)))
						seq_alt = int'($signed(ALT_MIN));
					offer_request(REQ_SAMPLE, ALT_W'(seq_alt), seq_time);
				end else if (pick < 86) begin
					offer_request(REQ_GROUND, ALT_W'($urandom), seq_time +
						($urandom_range(1) ? $urandom_range(0, age_lim) : $urandom_range(0, 70000)));
				end else begin
					noise_req = $urandom_range(1);
					noise_abs = ALT_W'($urandom);
					noise_t   = $urandom;
					offer_request(noise_req, noise_abs, noise_t);
					if (noise_req == REQ_SAMPLE) begin
						seq_time = noise_t;
						seq_alt  = int'($signed(noise_abs));
					end
				end
			end
			drain_results();
			ep++;
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("vario_vertical_speed_tracker regression: pass");
		else
			$display("vario_vertical_speed_tracker regression: fail");
		$finish;
	end
endmodule
